### rtl/core/tdp_pkg.sv
package tdp_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } tdp_state_e;

  localparam int unsigned FIRST_DIVISOR = 3;
  localparam int unsigned FIRST_SQUARE  = 9;
  localparam int unsigned DIVISOR_STEP  = 2;
  localparam int unsigned SQUARE_BIAS   = 4;

endpackage

### rtl/core/tdp_cell.sv
module tdp_cell #(
  parameter int unsigned DivisorWidth = 18
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    flush_i,
  input  logic                    valid_i,
  input  logic [DivisorWidth-1:0] divisor_i,
  input  logic [DivisorWidth-1:0] rem_i,
  input  logic                    bit_i,
  output logic                    valid_o,
  output logic [DivisorWidth-1:0] divisor_o,
  output logic [DivisorWidth-1:0] rem_o
);
  import tdp_pkg::*;

  logic [DivisorWidth:0]   shifted;
  logic [DivisorWidth:0]   diff;
  logic                    fits;
  logic                    valid_q;
  logic                    valid_d;
  logic [DivisorWidth-1:0] divisor_q;
  logic [DivisorWidth-1:0] rem_q;
  logic [DivisorWidth-1:0] rem_d;

  always_comb begin
    shifted = {rem_i, bit_i};
    diff    = shifted - {1'b0, divisor_i};
    fits    = (shifted >= {1'b0, divisor_i});
    rem_d   = fits ? diff[DivisorWidth-1:0] : shifted[DivisorWidth-1:0];
    valid_d = valid_i && !flush_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_i;
    rem_q     <= rem_d;
  end

  assign valid_o   = valid_q;
  assign divisor_o = divisor_q;
  assign rem_o     = rem_q;

endmodule

### rtl/core/tdp_chain.sv
module tdp_chain #(
  parameter int unsigned NumberWidth  = 32,
  parameter int unsigned DivisorWidth = 18
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    flush_i,
  input  logic                    valid_i,
  input  logic [DivisorWidth-1:0] divisor_i,
  input  logic [NumberWidth-1:0]  number_i,
  output logic                    hit_o,
  output logic                    busy_o
);
  import tdp_pkg::*;

  logic [NumberWidth:0]    valid;
  logic [DivisorWidth-1:0] divisor [NumberWidth+1];
  logic [DivisorWidth-1:0] rem     [NumberWidth+1];

  assign valid[0]   = valid_i;
  assign divisor[0] = divisor_i;
  assign rem[0]     = '0;

  for (genvar k = 0; k < NumberWidth; k++) begin : g_cell
    tdp_cell #(
      .DivisorWidth(DivisorWidth)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .flush_i  (flush_i),
      .valid_i  (valid[k]),
      .divisor_i(divisor[k]),
      .rem_i    (rem[k]),
      .bit_i    (number_i[NumberWidth-1-k]),
      .valid_o  (valid[k+1]),
      .divisor_o(divisor[k+1]),
      .rem_o    (rem[k+1])
    );
  end

  assign hit_o  = valid[NumberWidth] && (rem[NumberWidth] == '0);
  assign busy_o = |valid[NumberWidth:1];

endmodule

### rtl/core/trial_division_prime_test.sv
// Tests one unsigned number per transfer for primality by trial division and returns
// one flag per number. Zero, one, two, the even numbers and the odd numbers below nine
// are settled without a search. Any other number is divided by the odd divisors from 3
// upward while the square of the divisor does not exceed it; the divisors enter a chain
// of NUMBER_WIDTH restoring-division cells at one per cycle, each cell handling one
// dividend bit. A composite stops at the first divisor leaving a zero remainder. One
// number is in work at a time, and the next is taken while the previous flag still
// waits at the output.
module trial_division_prime_test #(
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [NUMBER_WIDTH-1:0] number_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    prime_flag_o
);
  import tdp_pkg::*;

  localparam int unsigned DivisorWidth = (NUMBER_WIDTH + 1) / 2 + 1;
  localparam int unsigned SquareWidth  = NUMBER_WIDTH + 2;

  tdp_state_e state_q, state_d;

  logic [NUMBER_WIDTH-1:0] n_q, n_d;
  logic [DivisorWidth-1:0] d_q, d_d;
  logic [SquareWidth-1:0]  sq_q, sq_d;
  logic                    flag_q, flag_d;
  logic                    out_valid_q, out_valid_d;
  logic                    prime_flag_q, prime_flag_d;

  logic                    accept;
  logic                    more;
  logic                    issue;
  logic                    flush;
  logic                    load_out;
  logic                    hit;
  logic                    busy;
  logic [SquareWidth-1:0]  n_ext;

  assign accept = in_valid_i && in_ready_o;
  assign n_ext  = {2'b00, n_q};
  assign more   = (sq_q <= n_ext);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (number_i[0] && (number_i >= NUMBER_WIDTH'(FIRST_SQUARE))) begin
            state_d = ST_RUN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_RUN: begin
        if (hit) begin
          state_d = ST_DONE;
        end else if (!more) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (hit || !busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    flush      = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_RUN: begin
        flush = hit;
        issue = more && !hit;
      end
      ST_DRAIN: flush = hit;
      ST_DONE:  load_out = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    n_d          = n_q;
    d_d          = d_q;
    sq_d         = sq_q;
    flag_d       = flag_q;
    out_valid_d  = out_valid_q;
    prime_flag_d = prime_flag_q;
    if (accept) begin
      n_d  = number_i;
      d_d  = DivisorWidth'(FIRST_DIVISOR);
      sq_d = SquareWidth'(FIRST_SQUARE);
      if (number_i < NUMBER_WIDTH'(2)) begin
        flag_d = 1'b0;
      end else if (number_i == NUMBER_WIDTH'(2)) begin
        flag_d = 1'b1;
      end else if (!number_i[0]) begin
        flag_d = 1'b0;
      end else begin
        flag_d = 1'b1;
      end
    end
    if (issue) begin
      d_d  = d_q + DivisorWidth'(DIVISOR_STEP);
      sq_d = sq_q + SquareWidth'({d_q, 2'b00}) + SquareWidth'(SQUARE_BIAS);
    end
    if (flush) begin
      flag_d = 1'b0;
    end else if (state_q == ST_DRAIN && !busy) begin
      flag_d = 1'b1;
    end
    if (load_out) begin
      out_valid_d  = 1'b1;
      prime_flag_d = flag_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    d_q          <= d_d;
    sq_q         <= sq_d;
    flag_q       <= flag_d;
    prime_flag_q <= prime_flag_d;
  end

  tdp_chain #(
    .NumberWidth (NUMBER_WIDTH),
    .DivisorWidth(DivisorWidth)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .flush_i  (flush),
    .valid_i  (issue),
    .divisor_i(d_q),
    .number_i (n_q),
    .hit_o    (hit),
    .busy_o   (busy)
  );

  assign out_valid_o  = out_valid_q;
  assign prime_flag_o = prime_flag_q;

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush |=> !busy)
    else $error("Divisor chain still busy after a flush.");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !busy)
    else $error("Divisor chain busy while a new number can be taken.");

  a_odd_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> d_q[0])
    else $error("Trial divisor is even.");

  a_hit_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> (state_q == ST_RUN || state_q == ST_DRAIN))
    else $error("Zero remainder seen outside a search.");

endmodule
